### design/csd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_pkg
// shared types, constants and the arctangent table of the disk mapper
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int unsigned FRAC_BITS_DEF   = 16;
    localparam int unsigned ANGLE_ITERS_DEF = 16;
    localparam int unsigned ATAN_LEN        = 24;

    localparam int unsigned COORD_W = 17;   // magnitude of a recentered coordinate
    localparam int unsigned CW      = 34;   // cordic datapath width
    localparam int unsigned ZW      = 32;   // binary angle width
    localparam int unsigned OUT_W   = 17;

    localparam logic [29:0] GAIN_INV = 30'd652032874;

    // sector offsets in units of pi/2 (0, 2, 4, 6 times pi/4)
    typedef enum logic [1:0] {
        SEC_E = 2'd0,
        SEC_N = 2'd1,
        SEC_W = 2'd2,
        SEC_S = 2'd3
    } t_sector;

    // control and radius carried alongside the divider
    typedef struct packed {
        logic [COORD_W-1:0] radius;
        t_sector            sector;
        logic               q_neg;
    } t_side;

    function automatic logic [ZW-1:0] atan_val(input int unsigned idx);
        logic [ZW-1:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### design/concentric_square_to_disk_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// concentric_square_to_disk_map
// maps a unit-square sample to the unit disk by the concentric mapping
// ----------------------------------------------------------------------------
// A fully pipelined mapper: one point is taken on every cycle that start is
// high (busy is always low) and its disk point appears on o_disk_x/o_disk_y
// with o_valid after passing through the sector select register, the
// divider, which makes one quotient bit per stage, the angle build register
// with the radius multiply, the cordic, which does one micro-rotation per
// stage, and the final rotate and round register. Results are shown for one
// cycle only and cannot be held off, so the receiver must take every beat as
// it comes. Outputs are signed Q1.15 in [-1, 1].
// ----------------------------------------------------------------------------
module concentric_square_to_disk_map #(
    parameter int unsigned FRAC_BITS        = csd_pkg::FRAC_BITS_DEF,
    parameter int unsigned ANGLE_ITERATIONS = csd_pkg::ANGLE_ITERS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [15:0]                      i_sample_u,
    input  logic [15:0]                      i_sample_v,
    output logic                             o_valid,
    output logic signed [csd_pkg::OUT_W-1:0] o_disk_x,
    output logic signed [csd_pkg::OUT_W-1:0] o_disk_y
);
    localparam int unsigned NIT = (ANGLE_ITERATIONS < csd_pkg::ATAN_LEN) ?
                                  ANGLE_ITERATIONS : csd_pkg::ATAN_LEN;
    localparam int unsigned LAT = 4 + FRAC_BITS + NIT;
    localparam int unsigned CWD = csd_pkg::COORD_W;

    // pipeline never stalls
    assign busy = 1'b0;

    // ---------------- stage 1: recenter and pick the sector ----------------
    logic signed [17:0] sx, sy;
    logic signed [17:0] num_s, den_s, rad_s;
    logic signed [17:0] num_abs, den_abs;
    logic               extra_neg;
    csd_pkg::t_sector   sec;

    assign sx = $signed({1'b0, i_sample_u, 1'b0}) - 18'sd65536;
    assign sy = $signed({1'b0, i_sample_v, 1'b0}) - 18'sd65536;

    always_comb begin
        num_s     = sy;
        den_s     = sx;
        rad_s     = sx;
        extra_neg = 1'b0;
        sec       = csd_pkg::SEC_E;
        if (sx > -sy) begin
            if (sx > sy) begin
                // east: r = x, angle = y/x
                num_s = sy;  den_s = sx;  rad_s = sx;
                sec   = csd_pkg::SEC_E;
            end else begin
                // north: angle = 2 - x/y
                num_s = sx;  den_s = sy;  rad_s = sy;
                sec   = csd_pkg::SEC_N;  extra_neg = 1'b1;
            end
        end else begin
            if (sx < sy) begin
                // west: angle = 4 + y/x
                num_s = sy;  den_s = sx;  rad_s = -sx;
                sec   = csd_pkg::SEC_W;
            end else if (sy != 18'sd0) begin
                // south: angle = 6 - x/y
                num_s = sx;  den_s = sy;  rad_s = -sy;
                sec   = csd_pkg::SEC_S;  extra_neg = 1'b1;
            end else begin
                // origin: zero angle, zero radius
                num_s = 18'sd0;  den_s = 18'sd1;  rad_s = 18'sd0;
                sec   = csd_pkg::SEC_E;
            end
        end
    end

    assign num_abs = num_s[17] ? -num_s : num_s;
    assign den_abs = den_s[17] ? -den_s : den_s;

    logic               r_a_vld;
    logic [CWD-1:0]     r_a_num, r_a_den;
    csd_pkg::t_side     r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_num         <= num_abs[CWD-1:0];
        r_a_den         <= den_abs[CWD-1:0];
        r_a_side.radius <= rad_s[CWD-1:0];
        r_a_side.sector <= sec;
        r_a_side.q_neg  <= num_s[17] ^ den_s[17] ^ extra_neg;
    end

    // ---------------- ratio of minor to dominant coordinate ----------------
    logic               d_vld;
    logic [FRAC_BITS:0] d_quot;
    csd_pkg::t_side     d_side;

    csd_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_vld),
        .i_num   (r_a_num),
        .i_den   (r_a_den),
        .i_side  (r_a_side),
        .o_valid (d_vld),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    // ---------------- angle build and cordic start vector ----------------
    // binary angle: 2^32 per turn, sector offset in quarter turns
    logic [csd_pkg::ZW-1:0] q_ext, q_sgn, ang, ang_sh;
    logic [46:0]            prod;

    assign q_ext  = {{(csd_pkg::ZW-FRAC_BITS-1){1'b0}}, d_quot};
    assign q_sgn  = d_side.q_neg ? (~q_ext + 32'd1) : q_ext;
    assign ang    = {d_side.sector, 30'd0} + (q_sgn << (29 - FRAC_BITS));
    assign ang_sh = ang + 32'h2000_0000;
    assign prod   = {13'd0, d_side.radius} * {17'd0, csd_pkg::GAIN_INV};

    logic                          r_b_vld;
    logic signed [csd_pkg::CW-1:0] r_b_x;
    logic signed [csd_pkg::ZW-1:0] r_b_z;
    logic [1:0]                    r_b_quad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_x    <= $signed({3'd0, prod[46:16]});
        r_b_quad <= ang_sh[31:30];
        r_b_z    <= $signed({2'b00, ang_sh[29:0]}) - 32'sh2000_0000;
    end

    // ---------------- cordic rotation ----------------
    logic                          c_vld;
    logic signed [csd_pkg::CW-1:0] c_x, c_y;
    logic [1:0]                    c_quad;

    csd_cordic #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_x     (r_b_x),
        .i_z     (r_b_z),
        .i_quad  (r_b_quad),
        .o_valid (c_vld),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_quad  (c_quad)
    );

    // ---------------- quadrant turn, round to Q1.15, saturate ----------------
    logic signed [csd_pkg::CW-1:0] fx, fy;

    always_comb begin
        case (c_quad)
            2'd1:    begin fx = -c_y; fy =  c_x; end
            2'd2:    begin fx = -c_x; fy = -c_y; end
            2'd3:    begin fx =  c_y; fy = -c_x; end
            default: begin fx =  c_x; fy =  c_y; end
        endcase
    end

    function automatic logic signed [csd_pkg::OUT_W-1:0] to_q115(
        input logic signed [csd_pkg::CW-1:0] v
    );
        logic signed [csd_pkg::CW-1:0] t;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32768)       return 17'sd32768;
        else if (t < -34'sd32768) return -17'sd32768;
        else                      return t[csd_pkg::OUT_W-1:0];
    endfunction

    logic                             r_o_vld;
    logic signed [csd_pkg::OUT_W-1:0] r_o_x, r_o_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_x <= to_q115(fx);
        r_o_y <= to_q115(fy);
    end

    assign o_valid  = r_o_vld;
    assign o_disk_x = r_o_x;
    assign o_disk_y = r_o_y;

    // ---------------- checks ----------------
    a_never_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised on a stall-free pipeline");

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result beat without a matching start");

    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_disk_x <= 17'sd32768 && o_disk_x >= -17'sd32768 &&
                     o_disk_y <= 17'sd32768 && o_disk_y >= -17'sd32768))
        else $error("disk point outside the unit range");

endmodule

### design/csd_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_divider
// pipelined restoring divider, one quotient bit per stage, q = num*2^F/den
// ----------------------------------------------------------------------------
module csd_divider #(
    parameter int unsigned FRAC_BITS = csd_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [csd_pkg::COORD_W-1:0]  i_num,
    input  logic [csd_pkg::COORD_W-1:0]  i_den,
    input  csd_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [FRAC_BITS:0]           o_quot,
    output csd_pkg::t_side               o_side
);
    localparam int unsigned NS = FRAC_BITS + 1;
    localparam int unsigned RW = csd_pkg::COORD_W + 1;

    logic                        r_vld  [0:NS-1];
    logic [RW-1:0]               r_rem  [0:NS-1];
    logic [csd_pkg::COORD_W-1:0] r_den  [0:NS-1];
    logic [FRAC_BITS:0]          r_quot [0:NS-1];
    csd_pkg::t_side              r_side [0:NS-1];

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            logic                        vld_in;
            logic [RW-1:0]               rem_in;
            logic [csd_pkg::COORD_W-1:0] den_in;
            logic [FRAC_BITS:0]          quot_in;
            logic [FRAC_BITS:0]          quot_out;
            csd_pkg::t_side              side_in;
            logic [RW-1:0]               trial;
            logic                        take;

            if (s == 0) begin : g_first
                assign vld_in  = i_valid;
                assign rem_in  = {1'b0, i_num};
                assign den_in  = i_den;
                assign quot_in = '0;
                assign side_in = i_side;
                assign trial   = rem_in;
            end else begin : g_next
                assign vld_in  = r_vld[s-1];
                assign rem_in  = r_rem[s-1];
                assign den_in  = r_den[s-1];
                assign quot_in = r_quot[s-1];
                assign side_in = r_side[s-1];
                assign trial   = {rem_in[RW-2:0], 1'b0};
            end

            assign take = (trial >= {1'b0, den_in});

            // this stage settles one quotient bit
            always_comb begin
                quot_out                = quot_in;
                quot_out[FRAC_BITS-s]   = take;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[s]  <= take ? (trial - {1'b0, den_in}) : trial;
                r_den[s]  <= den_in;
                r_side[s] <= side_in;
                r_quot[s] <= quot_out;
            end
        end
    endgenerate

    assign o_valid = r_vld[NS-1];
    assign o_quot  = r_quot[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

### design/csd_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_cordic
// pipelined rotation-mode cordic, one micro-rotation per stage
// ----------------------------------------------------------------------------
module csd_cordic #(
    parameter int unsigned ANGLE_ITERATIONS = csd_pkg::ANGLE_ITERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [csd_pkg::CW-1:0]  i_x,
    input  logic signed [csd_pkg::ZW-1:0]  i_z,
    input  logic [1:0]                     i_quad,
    output logic                           o_valid,
    output logic signed [csd_pkg::CW-1:0]  o_x,
    output logic signed [csd_pkg::CW-1:0]  o_y,
    output logic [1:0]                     o_quad
);
    localparam int unsigned NIT = (ANGLE_ITERATIONS < csd_pkg::ATAN_LEN) ?
                                  ANGLE_ITERATIONS : csd_pkg::ATAN_LEN;

    logic                          r_vld  [0:NIT-1];
    logic signed [csd_pkg::CW-1:0] r_x    [0:NIT-1];
    logic signed [csd_pkg::CW-1:0] r_y    [0:NIT-1];
    logic signed [csd_pkg::ZW-1:0] r_z    [0:NIT-1];
    logic [1:0]                    r_quad [0:NIT-1];

    genvar i;
    generate
        for (i = 0; i < NIT; i++) begin : g_rot
            logic                          vld_in;
            logic signed [csd_pkg::CW-1:0] x_in;
            logic signed [csd_pkg::CW-1:0] y_in;
            logic signed [csd_pkg::ZW-1:0] z_in;
            logic [1:0]                    quad_in;
            logic signed [csd_pkg::CW-1:0] xs;
            logic signed [csd_pkg::CW-1:0] ys;
            logic signed [csd_pkg::ZW-1:0] at;

            if (i == 0) begin : g_first
                assign vld_in  = i_valid;
                assign x_in    = i_x;
                assign y_in    = '0;
                assign z_in    = i_z;
                assign quad_in = i_quad;
            end else begin : g_next
                assign vld_in  = r_vld[i-1];
                assign x_in    = r_x[i-1];
                assign y_in    = r_y[i-1];
                assign z_in    = r_z[i-1];
                assign quad_in = r_quad[i-1];
            end

            assign xs = x_in >>> i;
            assign ys = y_in >>> i;
            assign at = $signed(csd_pkg::atan_val(i));

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[i] <= 1'b0;
                end else begin
                    r_vld[i] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_quad[i] <= quad_in;
                if (!z_in[csd_pkg::ZW-1]) begin
                    r_x[i] <= x_in - ys;
                    r_y[i] <= y_in + xs;
                    r_z[i] <= z_in - at;
                end else begin
                    r_x[i] <= x_in + ys;
                    r_y[i] <= y_in - xs;
                    r_z[i] <= z_in + at;
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[NIT-1];
    assign o_x     = r_x[NIT-1];
    assign o_y     = r_y[NIT-1];
    assign o_quad  = r_quad[NIT-1];

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the concentric square-to-disk mapper
// ----------------------------------------------------------------------------
// Sample points go in through the start/busy command port. A local bit-exact
// model of the sector select, ratio, binary angle and cordic rotation
// predicts each disk point. The receiving side cannot stall, so every o_valid
// beat is checked on the spot against the oldest prediction. The run starts
// with a short table of corner, axis and sector-boundary points, then
// streams random points through three idle-pattern phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC    = csd_pkg::FRAC_BITS_DEF;
    localparam int N_ITERS = (csd_pkg::ANGLE_ITERS_DEF < csd_pkg::ATAN_LEN) ?
                             csd_pkg::ANGLE_ITERS_DEF : csd_pkg::ATAN_LEN;
    localparam int LATENCY = 4 + FRAC + N_ITERS;
    localparam int STALL_LIMIT = 2000;   // cycles with no beat at all
    localparam int PHASE_POINTS = 560;
    localparam int N_ROWS = 20;
    localparam longint GAIN_INV_Q30 = 64'd652032874;

    typedef struct {
        logic signed [csd_pkg::OUT_W-1:0] x;
        logic signed [csd_pkg::OUT_W-1:0] y;
    } t_disk_pt;

    // directed row: the disk point is typed in only where it is obvious
    typedef struct {
        logic [15:0]                      u;
        logic [15:0]                      v;
        bit                               known;
        logic signed [csd_pkg::OUT_W-1:0] x;
        logic signed [csd_pkg::OUT_W-1:0] y;
    } t_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    logic [15:0]                      i_sample_u;
    logic [15:0]                      i_sample_v;
    logic                             o_valid;
    logic signed [csd_pkg::OUT_W-1:0] o_disk_x;
    logic signed [csd_pkg::OUT_W-1:0] o_disk_y;

    t_disk_pt pending_pts[$];
    int       mismatches = 0;
    int       quiet_cycles = 0;
    int       send_idle_pct = 0;

    // arctangents of 2^-i as binary angles, 2^32 per turn
    longint arctan_steps [0:csd_pkg::ATAN_LEN-1] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304,
        652, 326, 163, 81
    };

    t_row dir_rows [0:N_ROWS-1] = '{
        '{16'd32768, 16'd32768, 1'b1, 17'sd0, 17'sd0},   // origin: zero angle
        '{16'd0,     16'd0,     1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'd65535, 1'b0, 17'sd0, 17'sd0},
        '{16'd0,     16'd65535, 1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'd0,     1'b0, 17'sd0, 17'sd0},
        '{16'd65535, 16'd32768, 1'b0, 17'sd0, 17'sd0},   // rim on the axes
        '{16'd32768, 16'd65535, 1'b0, 17'sd0, 17'sd0},
        '{16'd0,     16'd32768, 1'b0, 17'sd0, 17'sd0},
        '{16'd32768, 16'd0,     1'b0, 17'sd0, 17'sd0},
        '{16'd32769, 16'd32768, 1'b0, 17'sd0, 17'sd0},   // one step off center
        '{16'd32768, 16'd32769, 1'b0, 17'sd0, 17'sd0},
        '{16'd32767, 16'd32768, 1'b0, 17'sd0, 17'sd0},
        '{16'd32768, 16'd32767, 1'b0, 17'sd0, 17'sd0},
        '{16'd49152, 16'd40960, 1'b0, 17'sd0, 17'sd0},
        '{16'd16384, 16'd24576, 1'b0, 17'sd0, 17'sd0},
        '{16'd40000, 16'd20000, 1'b0, 17'sd0, 17'sd0},
        '{16'd1,     16'd65534, 1'b0, 17'sd0, 17'sd0},
        '{16'd65534, 16'd1,     1'b0, 17'sd0, 17'sd0},
        '{16'hAAAA,  16'h5555,  1'b0, 17'sd0, 17'sd0},
        '{16'h5555,  16'hAAAA,  1'b0, 17'sd0, 17'sd0}
    };

    concentric_square_to_disk_map dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_sample_u (i_sample_u),
        .i_sample_v (i_sample_v),
        .o_valid    (o_valid),
        .o_disk_x   (o_disk_x),
        .o_disk_y   (o_disk_y)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // |num|/|den| in units of 2^-FRAC, truncated toward zero, signed
    function automatic longint signed_ratio(longint num, longint den);
        longint an;
        longint ad;
        longint quo;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        if (ad == 0) begin
            return 0;
        end
        quo = (an << FRAC) / ad;
        return ((num < 0) != (den < 0)) ? -quo : quo;
    endfunction

    // round a 2^-30 value to Q1.15 and clamp to [-1, 1]
    function automatic logic signed [csd_pkg::OUT_W-1:0] round_q115(longint val);
        longint o;
        o = (val + 64'sd16384) >>> 15;
        if (o > 32768) begin
            o = 32768;
        end
        if (o < -32768) begin
            o = -32768;
        end
        return o[csd_pkg::OUT_W-1:0];
    endfunction

    function automatic t_disk_pt square_to_disk(logic [15:0] u, logic [15:0] v);
        longint     sx;
        longint     sy;
        longint     r;
        longint     q;
        longint     off;
        longint     x;
        longint     y;
        longint     z;
        longint     nx;
        longint     ny;
        logic [63:0] ang;
        logic [31:0] turn;
        t_disk_pt   pt;
        sx = 2 * longint'({1'b0, u}) - 65536;
        sy = 2 * longint'({1'b0, v}) - 65536;
        // sector pick: east, north, west, south
        if (sx > -sy) begin
            if (sx > sy) begin
                r = sx; off = 0; q = signed_ratio(sy, sx);
            end else begin
                r = sy; off = 2; q = -signed_ratio(sx, sy);
            end
        end else begin
            if (sx < sy) begin
                r = -sx; off = 4; q = signed_ratio(sy, sx);
            end else begin
                r = -sy;
                if (sy != 0) begin
                    off = 6; q = -signed_ratio(sx, sy);
                end else begin
                    off = 0; q = 0;
                end
            end
        end
        ang  = (64'(off) << FRAC) + 64'(q);
        ang  = ang << (29 - FRAC);
        turn = ang[31:0] + 32'h2000_0000;
        z    = longint'({34'd0, turn[29:0]}) - 64'sd536870912;
        x    = (r * GAIN_INV_Q30) >>> 16;
        y    = 0;
        for (int i = 0; i < N_ITERS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - arctan_steps[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + arctan_steps[i];
            end
            x = nx;
            y = ny;
        end
        // quarter turns left over from the angle reduction
        case (turn[31:30])
            2'd1:    begin nx = -y; ny = x;  end
            2'd2:    begin nx = -x; ny = -y; end
            2'd3:    begin nx = y;  ny = -x; end
            default: begin nx = x;  ny = y;  end
        endcase
        pt.x = round_q115(nx);
        pt.y = round_q115(ny);
        return pt;
    endfunction

    // one point, called at a falling edge, returns at a falling edge
    task automatic drive_point(logic [15:0] u, logic [15:0] v, bit known,
                               t_disk_pt typed);
        // each cycle idles with the chosen odds
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_sample_u <= u;
        i_sample_v <= v;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_pts.insert(pending_pts.size(),
                           known ? typed : square_to_disk(u, v));
        @(negedge i_clk);
    endtask

    task automatic drive_random_points(int count);
        logic [15:0] u;
        logic [15:0] v;
        int          pick;
        t_disk_pt    none;
        none = '{17'sd0, 17'sd0};
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            u = 16'($urandom_range(65535));
            v = 16'($urandom_range(65535));
            if (pick < 10) begin
                v = u;                                   // main diagonal
            end else if (pick < 20) begin
                v = 16'(17'd65536 - {1'b0, u});          // anti diagonal
            end else if (pick < 30) begin
                u = 16'(32768 + $urandom_range(64) - 32);   // near center
                v = 16'(32768 + $urandom_range(64) - 32);
            end else if (pick < 40) begin
                u = $urandom_range(1) ? 16'($urandom_range(65535, 65500))
                                      : 16'($urandom_range(35));   // near rim
            end
            drive_point(u, v, 1'b0, none);
        end
    endtask

    // every beat is checked as it comes
    always @(posedge i_clk) begin
        t_disk_pt want;
        if (i_rst_n && o_valid) begin
            if (pending_pts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected disk point x=%0d y=%0d", o_disk_x, o_disk_y);
                end
            end else begin
                want = pending_pts.pop_front();
                if (o_disk_x !== want.x || o_disk_y !== want.y) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("disk point mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                 want.x, want.y, o_disk_x, o_disk_y);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        t_disk_pt typed;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_sample_u = '0;
        i_sample_v = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed points, back to back
        for (int n = 0; n < N_ROWS; n++) begin
            typed = '{dir_rows[n].x, dir_rows[n].y};
            drive_point(dir_rows[n].u, dir_rows[n].v, dir_rows[n].known, typed);
        end

        // hold off until the pipeline has drained
        start <= 1'b0;
        while (pending_pts.size() != 0) begin
            @(negedge i_clk);
        end

        // sender idles rarely, then often, then never
        send_idle_pct = 11;
        drive_random_points(PHASE_POINTS);
        send_idle_pct = 83;
        drive_random_points(PHASE_POINTS);
        send_idle_pct = 0;
        drive_random_points(PHASE_POINTS);
        start <= 1'b0;

        while (pending_pts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 10) @(posedge i_clk);

        if (mismatches == 0 && pending_pts.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
